[rtl/core/riff_wave_pcm_stream_parser_unit_defines.svh]
// Assertion macros shared by the parser modules.
`ifndef RIFF_WAVE_PCM_STREAM_PARSER_UNIT_DEFINES_SVH
`define RIFF_WAVE_PCM_STREAM_PARSER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RWP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define RWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/rwp_pkg.sv]
// ----------------------------------------------------------------------------
// RIFF WAVE parser package
// Shared constants, types and the result record passed between the parts.
// ----------------------------------------------------------------------------
package rwp_pkg;

  localparam int unsigned MaxChannelsDefault = 8;
  localparam int unsigned QueueDepth         = 2;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NOT_RIFF = 2'd0,
    ERR_NOT_WAVE = 2'd1,
    ERR_NOT_PCM  = 2'd2,
    ERR_UNSUP    = 2'd3
  } err_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [2:0]  channel_index;
    logic [31:0] sample_value;
    logic [31:0] sample_rate;
    logic [3:0]  channel_count;
    logic [5:0]  bits_per_sample;
    logic        last_in_chunk;
  } result_t;

endpackage

[rtl/core/rwp_front.sv]
// ----------------------------------------------------------------------------
// RIFF WAVE parser front end
// Walks the file structure byte by byte and forms at most one result a byte.
// ----------------------------------------------------------------------------
module rwp_front #(
  parameter int unsigned MaxChannels = rwp_pkg::MaxChannelsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             start_of_file_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output rwp_pkg::result_t res_o
);
  import rwp_pkg::*;

  localparam logic [3:0] PhRiffTag  = 4'd0;
  localparam logic [3:0] PhRiffSize = 4'd1;
  localparam logic [3:0] PhWaveTag  = 4'd2;
  localparam logic [3:0] PhPreId    = 4'd3;
  localparam logic [3:0] PhPreSize  = 4'd4;
  localparam logic [3:0] PhPreSkip  = 4'd5;
  localparam logic [3:0] PhFmtSize  = 4'd6;
  localparam logic [3:0] PhFmtBody  = 4'd7;
  localparam logic [3:0] PhPostId   = 4'd8;
  localparam logic [3:0] PhPostSize = 4'd9;
  localparam logic [3:0] PhPostSkip = 4'd10;
  localparam logic [3:0] PhSamples  = 4'd11;
  localparam logic [3:0] PhHalt     = 4'd12;
  localparam logic [3:0] PhRemWait  = 4'd13;

  logic [3:0]  phase_q, phase_d;
  logic [31:0] shift_q, shift_d;
  logic [1:0]  fcnt_q, fcnt_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] data_q, data_d;
  logic [4:0]  chans_q, chans_d;
  logic [31:0] rate_q, rate_d;
  logic [5:0]  bits_q, bits_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  bidx_q, bidx_d;
  logic [3:0]  chan_q, chan_d;
  logic        dchunk_q, dchunk_d;
  logic [3:0]  fpos_q, fpos_d;
  // Remainder unit: size mod frame by restoring subtraction, one bit a cycle.
  logic [31:0] rsize_q, rsize_d;
  logic [31:0] rrem_q, rrem_d;
  logic [5:0]  rcnt_q, rcnt_d;
  logic [6:0]  frame_q, frame_d;

  result_t     res_d;
  logic        emit;
  logic        take;
  logic        busy;

  always_comb begin
    busy = (phase_q == PhRemWait);
    ready_o = res_ready_i && !busy;
  end
  assign take = valid_i && ready_o;

  function automatic logic [31:0] padded(input logic [31:0] s);
    logic [32:0] t;
    t = {1'b0, s} + {32'd0, s[0]};
    return t[32] ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  always_comb begin
    logic [3:0]  ph;
    logic [31:0] sh;
    logic        full;
    logic [15:0] v16;
    logic [31:0] t;
    logic [1:0]  nb;
    logic [31:0] acc;
    logic [31:0] dr;
    logic [32:0] trial;
    phase_d = phase_q; shift_d = shift_q; fcnt_d = fcnt_q; skip_d = skip_q;
    data_d = data_q; chans_d = chans_q; rate_d = rate_q; bits_d = bits_q;
    acc_d = acc_q; bidx_d = bidx_q; chan_d = chan_q; dchunk_d = dchunk_q;
    fpos_d = fpos_q; rsize_d = rsize_q; rrem_d = rrem_q; rcnt_d = rcnt_q;
    frame_d = frame_q;
    emit = 1'b0;
    res_d = '0;
    ph = phase_q; sh = shift_q; full = 1'b0; v16 = '0; t = '0; nb = '0;
    acc = '0; dr = '0; trial = '0;
    if (busy) begin
      trial = {rrem_q, rsize_q[31]} - {26'd0, frame_q};
      if (!trial[32]) begin
        rrem_d = trial[31:0];
      end else begin
        rrem_d = {rrem_q[30:0], rsize_q[31]};
      end
      rsize_d = {rsize_q[30:0], 1'b0};
      rcnt_d = rcnt_q - 6'd1;
      if (rcnt_q == 6'd1) begin
        dr = shift_q - rrem_d;
        data_d = dr;
        skip_d = rrem_d + {31'd0, shift_q[0]};
        phase_d = (dr != 0) ? PhSamples : ((skip_d != 0) ? PhPostSkip : PhPostId);
      end
    end else if (take) begin
      if (start_of_file_i) begin
        ph = PhRiffTag; sh = '0; chans_d = '0; rate_d = '0; bits_d = '0;
        skip_d = '0; data_d = '0; acc_d = '0; bidx_d = '0; chan_d = '0;
        dchunk_d = 1'b0; fcnt_d = '0; fpos_d = '0;
        full = 1'b0;
      end
      shift_d = {data_byte_i, sh[31:8]};
      if (!start_of_file_i || 1'b1) begin
        full = ((start_of_file_i ? 2'd0 : fcnt_q) == 2'd3);
      end
      phase_d = ph;
      case (ph)
        PhRiffTag, PhRiffSize, PhWaveTag, PhPreId, PhPreSize, PhFmtSize,
        PhPostId, PhPostSize: begin
          fcnt_d = full ? 2'd0 : ((start_of_file_i ? 2'd0 : fcnt_q) + 2'd1);
          if (full) begin
            case (ph)
              PhRiffTag: begin
                if (shift_d != TagRiff) begin
                  phase_d = PhHalt; emit = 1'b1;
                  res_d.kind = KIND_ERROR; res_d.error_code = ERR_NOT_RIFF;
                end else phase_d = PhRiffSize;
              end
              PhRiffSize: phase_d = PhWaveTag;
              PhWaveTag: begin
                if (shift_d != TagWave) begin
                  phase_d = PhHalt; emit = 1'b1;
                  res_d.kind = KIND_ERROR; res_d.error_code = ERR_NOT_WAVE;
                end else phase_d = PhPreId;
              end
              PhPreId: phase_d = (shift_d == TagFmt) ? PhFmtSize : PhPreSize;
              PhPreSize: begin
                skip_d = padded(shift_d);
                phase_d = (skip_d != 0) ? PhPreSkip : PhPreId;
              end
              PhFmtSize: begin
                t = padded(shift_d);
                skip_d = (t > 32'd16) ? t - 32'd16 : 32'd0;
                data_d = '0; fpos_d = '0;
                phase_d = PhFmtBody;
              end
              PhPostId: begin
                dchunk_d = (shift_d == TagData);
                phase_d = PhPostSize;
              end
              default: begin
                if (dchunk_q) begin
                  acc_d = '0; bidx_d = '0; chan_d = '0;
                  if (frame_q == 0) begin
                    data_d = '0;
                    skip_d = shift_d + {31'd0, shift_d[0]};
                    phase_d = (skip_d != 0) ? PhPostSkip : PhPostId;
                  end else begin
                    rsize_d = shift_d; rrem_d = '0; rcnt_d = 6'd32;
                    phase_d = PhRemWait;
                  end
                end else begin
                  skip_d = padded(shift_d);
                  phase_d = (skip_d != 0) ? PhPostSkip : PhPostId;
                end
              end
            endcase
          end
        end
        PhPreSkip, PhPostSkip: begin
          shift_d = shift_q;
          t = (skip_q != 0) ? skip_q - 32'd1 : skip_q;
          skip_d = t;
          if (t == 0) phase_d = (ph == PhPreSkip) ? PhPreId : PhPostId;
        end
        PhFmtBody: begin
          v16 = shift_d[31:16];
          fpos_d = fpos_q + 4'd1;
          if (fpos_q == 4'd1) begin
            if (v16 != 16'd1) begin
              phase_d = PhHalt; emit = 1'b1;
              res_d.kind = KIND_ERROR; res_d.error_code = ERR_NOT_PCM;
            end
          end else if (fpos_q == 4'd3) begin
            if (v16 == 16'd0 || v16 > 16'(MaxChannels)) begin
              phase_d = PhHalt; emit = 1'b1;
              res_d.kind = KIND_ERROR; res_d.error_code = ERR_UNSUP;
            end else chans_d = v16[4:0];
          end else if (fpos_q == 4'd7) begin
            rate_d = shift_d;
          end else if (fpos_q == 4'd15) begin
            if (v16 != 16'd8 && v16 != 16'd16 && v16 != 16'd24 && v16 != 16'd32)
            begin
              phase_d = PhHalt; emit = 1'b1;
              res_d.kind = KIND_ERROR; res_d.error_code = ERR_UNSUP;
            end else begin
              bits_d = v16[5:0];
              data_d = '0; fcnt_d = '0;
              frame_d = 7'({2'd0, chans_q} * {4'd0, v16[5:3]});
              phase_d = (skip_q != 0) ? PhPostSkip : PhPostId;
              emit = 1'b1;
              res_d.kind = KIND_FORMAT;
              res_d.sample_rate = rate_q;
              res_d.channel_count = chans_q[3:0];
              res_d.bits_per_sample = v16[5:0];
            end
          end
        end
        PhSamples: begin
          shift_d = shift_q;
          nb = bits_q[4:3] - 2'd1;
          acc = acc_q;
          case (bidx_q)
            2'd0: acc[7:0] = acc_q[7:0] | data_byte_i;
            2'd1: acc[15:8] = acc_q[15:8] | data_byte_i;
            2'd2: acc[23:16] = acc_q[23:16] | data_byte_i;
            default: acc[31:24] = acc_q[31:24] | data_byte_i;
          endcase
          dr = (data_q != 0) ? data_q - 32'd1 : data_q;
          data_d = dr;
          if (bidx_q == nb) begin
            emit = 1'b1;
            res_d.kind = KIND_SAMPLE;
            res_d.channel_index = chan_q[2:0];
            if (bits_q == 6'd8) res_d.sample_value = {acc[7] ^ 1'b1, acc[6:0], 24'd0};
            else if (bits_q == 6'd16) res_d.sample_value = {acc[15:0], 16'd0};
            else if (bits_q == 6'd24) res_d.sample_value = {acc[23:0], 8'd0};
            else res_d.sample_value = acc;
            res_d.sample_rate = rate_q;
            res_d.channel_count = chans_q[3:0];
            res_d.bits_per_sample = bits_q;
            res_d.last_in_chunk = (dr == 0);
            acc_d = '0; bidx_d = '0;
            chan_d = ({1'b0, chan_q} + 5'd1 >= chans_q) ? 4'd0 : chan_q + 4'd1;
          end else begin
            acc_d = acc; bidx_d = bidx_q + 2'd1;
          end
          if (dr == 0) begin
            fcnt_d = '0;
            phase_d = (skip_q != 0) ? PhPostSkip : PhPostId;
          end
        end
        default: shift_d = shift_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhRiffTag; shift_q <= '0; fcnt_q <= '0; skip_q <= '0;
      data_q <= '0; chans_q <= '0; rate_q <= '0; bits_q <= '0; acc_q <= '0;
      bidx_q <= '0; chan_q <= '0; dchunk_q <= 1'b0; fpos_q <= '0;
      rcnt_q <= '0; frame_q <= '0;
    end else begin
      phase_q <= phase_d; shift_q <= shift_d; fcnt_q <= fcnt_d; skip_q <= skip_d;
      data_q <= data_d; chans_q <= chans_d; rate_q <= rate_d; bits_q <= bits_d;
      acc_q <= acc_d; bidx_q <= bidx_d; chan_q <= chan_d; dchunk_q <= dchunk_d;
      fpos_q <= fpos_d; rcnt_q <= rcnt_d; frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsize_q <= rsize_d;
    rrem_q  <= rrem_d;
  end

  assign res_valid_o = take && emit;
  assign res_o = res_d;

endmodule

[rtl/core/rwp_queue.sv]
// ----------------------------------------------------------------------------
// RIFF WAVE parser result queue
// Small first-in first-out store between the front end and the output.
// ----------------------------------------------------------------------------
`include "riff_wave_pcm_stream_parser_unit_defines.svh"
module rwp_queue #(
  parameter int unsigned Depth = rwp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  rwp_pkg::result_t wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output rwp_pkg::result_t rd_data_o
);
  import rwp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0; rptr_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      if (pop)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  `RWP_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, cnt_q == (PtrW+1)'(Depth), !push)
  `RWP_ASSERT_NEXT(a_push_only, clk_i, rst_ni, push && !pop, cnt_q != '0)
  `RWP_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= (PtrW+1)'(Depth))

endmodule

[rtl/core/riff_wave_pcm_stream_parser_unit.sv]
// ----------------------------------------------------------------------------
// RIFF WAVE PCM stream parser
// Byte-wide WAV file parser giving format, error and sample records.
// ----------------------------------------------------------------------------
// Use: bytes enter on the input channel (data_byte_i, start_of_file_i) with a
// valid and ready handshake; start_of_file_i on the first byte of a file
// restarts parsing. Results leave on the output channel, one field a port.
// A byte is taken each cycle while the result queue has room and the front end
// is not busy, so one byte a cycle is then sustained; results are registered
// in the queue. After the size field of a data chunk with a nonzero frame
// length the front end works out the remainder of the size by the frame length,
// one bit a cycle in a subtract unit, and takes no byte meanwhile.
// After an error, bytes are swallowed until a new start of file.
// Reset clears the parser to wait for the RIFF tag and empties the queue.
// When the receiver stalls, the queue fills and input ready falls; nothing
// is lost.
// ----------------------------------------------------------------------------
`include "riff_wave_pcm_stream_parser_unit_defines.svh"
module riff_wave_pcm_stream_parser_unit #(
  parameter int unsigned MaxChannels = rwp_pkg::MaxChannelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  error_code_o,
  output logic [2:0]  channel_index_o,
  output logic signed [31:0] sample_value_o,
  output logic [31:0] sample_rate_o,
  output logic [3:0]  channel_count_o,
  output logic [5:0]  bits_per_sample_o,
  output logic        last_in_chunk_o
);
  import rwp_pkg::*;

  logic    fr_valid, q_ready;
  result_t fr_res, q_res;
  logic    q_wr_valid;

  // The queue must hold the result of any byte taken, so take needs room.
  rwp_front #(.MaxChannels(MaxChannels)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .data_byte_i, .start_of_file_i,
    .res_valid_o(fr_valid), .res_ready_i(q_ready), .res_o(fr_res)
  );

  assign q_wr_valid = fr_valid;

  rwp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(q_wr_valid), .wr_ready_o(q_ready), .wr_data_i(fr_res),
    .rd_valid_o(valid_o), .rd_ready_i(ready_i), .rd_data_o(q_res)
  );

  assign kind_o            = q_res.kind;
  assign error_code_o      = q_res.error_code;
  assign channel_index_o   = q_res.channel_index;
  assign sample_value_o    = q_res.sample_value;
  assign sample_rate_o     = q_res.sample_rate;
  assign channel_count_o   = q_res.channel_count;
  assign bits_per_sample_o = q_res.bits_per_sample;
  assign last_in_chunk_o   = q_res.last_in_chunk;

  `RWP_ASSERT_IMP(a_ready_room, clk_i, rst_ni, ready_o, q_ready)
  `RWP_ASSERT_IMP(a_kind_legal, clk_i, rst_ni, valid_o, kind_o != 2'd3)
  `RWP_ASSERT_IMP(a_err_clean, clk_i, rst_ni, valid_o && kind_o == KIND_ERROR,
    sample_rate_o == '0 && last_in_chunk_o == 1'b0)

endmodule
